>>> rtl/ngga_pkg.sv
// Shared types, constants and lookup functions for the GGA sentence parser.
`default_nettype none

package ngga_pkg;

	// Field widths of the result and configuration
	localparam int TIME_W  = 20;
	localparam int COORD_W = 34;
	localparam int ZONE_W  = 5;

	// Internal counter widths, sized for the top of each parameter range
	localparam int CNT_W  = 4;
	localparam int FRAC_W = 3;

	// Parameter defaults
	localparam int TIME_DIGITS_DEF     = 6;
	localparam int MAX_COORD_CHARS_DEF = 15;
	localparam int FRACTION_DIGITS_DEF = 5;

	// Decoupling queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	localparam int HDR_LEN = 5;
	localparam int HDR_W   = 3;

	localparam logic [ZONE_W-1:0]  ZONE_RESET = 5'd8;
	localparam logic [ZONE_W-1:0]  ZONE_WRAP  = 5'd24;
	localparam logic [17:0]        HOUR_STEP  = 18'd10000;
	localparam logic [20:0]        DAY_TIME   = 21'd240000;
	localparam logic [COORD_W-1:0] COORD_CAP  = 34'd9999999999;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_G      = 8'h47;
	localparam logic [7:0] CHAR_P      = 8'h50;
	localparam logic [7:0] CHAR_A      = 8'h41;

	// One received byte after classification
	typedef struct packed {
		logic               dollar;
		logic               comma;
		logic               dot;
		logic               is_digit;
		logic [3:0]         digit;
		logic [HDR_LEN-1:0] hdr_hit;
	} byte_class_t;

	// Raw sentence values handed from the parser to the finishing stage
	typedef struct packed {
		logic [TIME_W-1:0]  time_raw;
		logic [COORD_W-1:0] lat_raw;
		logic [FRAC_W-1:0]  lat_frac;
		logic [COORD_W-1:0] lon_raw;
		logic [FRAC_W-1:0]  lon_frac;
	} raw_result_t;

	// Expected header character "GPGGA" at each position
	function automatic logic [7:0] hdr_char(input logic [HDR_W-1:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = CHAR_G;
			3'd1:    c = CHAR_P;
			3'd2:    c = CHAR_G;
			3'd3:    c = CHAR_G;
			3'd4:    c = CHAR_A;
			default: c = CHAR_DOLLAR;
		endcase
		return c;
	endfunction

	// Power of ten for the missing fraction digits
	function automatic logic [23:0] pow10(input logic [FRAC_W-1:0] m);
		logic [23:0] p;
		unique case (m)
			3'd0:    p = 24'd1;
			3'd1:    p = 24'd10;
			3'd2:    p = 24'd100;
			3'd3:    p = 24'd1000;
			3'd4:    p = 24'd10000;
			3'd5:    p = 24'd100000;
			3'd6:    p = 24'd1000000;
			default: p = 24'd10000000;
		endcase
		return p;
	endfunction

	// Largest value that scales by pow10(m) without passing the cap
	function automatic logic [COORD_W-1:0] scale_limit(input logic [FRAC_W-1:0] m);
		logic [COORD_W-1:0] l;
		unique case (m)
			3'd0:    l = 34'd9999999999;
			3'd1:    l = 34'd999999999;
			3'd2:    l = 34'd99999999;
			3'd3:    l = 34'd9999999;
			3'd4:    l = 34'd999999;
			3'd5:    l = 34'd99999;
			3'd6:    l = 34'd9999;
			default: l = 34'd999;
		endcase
		return l;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ngga_front.sv
// Input stage: takes bytes, classifies them and pushes them into the queue.
`default_nettype none

module ngga_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                q_full,
	output logic                     q_push,
	output ngga_pkg::byte_class_t    q_wdata
);

	ngga_pkg::byte_class_t cls;
	ngga_pkg::byte_class_t cls_s1;
	logic                  valid_s1;
	logic                  take;

	always_comb begin
		cls          = '0;
		cls.dollar   = (rx_byte == ngga_pkg::CHAR_DOLLAR);
		cls.comma    = (rx_byte == ngga_pkg::CHAR_COMMA);
		cls.dot      = (rx_byte == ngga_pkg::CHAR_DOT);
		cls.is_digit = (rx_byte >= ngga_pkg::CHAR_ZERO) && (rx_byte <= ngga_pkg::CHAR_NINE);
		cls.digit    = rx_byte[3:0];
		for (int i = 0; i < ngga_pkg::HDR_LEN; i++) begin
			cls.hdr_hit[i] = (rx_byte == ngga_pkg::hdr_char(ngga_pkg::HDR_W'(i)));
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign take     = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_wdata  = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ngga_queue.sv
// Short FIFO of classified bytes between the front and the parser.
`default_nettype none

module ngga_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ngga_pkg::byte_class_t wdata,
	input  wire logic                  pop,
	output ngga_pkg::byte_class_t      rdata,
	output logic                       nonempty,
	output logic                       full
);

	ngga_pkg::byte_class_t           entry_q [ngga_pkg::Q_DEPTH];
	logic [ngga_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [ngga_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [ngga_pkg::Q_PTR_W:0]      count_q;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == (ngga_pkg::Q_PTR_W+1)'(ngga_pkg::Q_DEPTH));
	assign rdata    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (ngga_pkg::Q_PTR_W+1)'(ngga_pkg::Q_DEPTH))
		else $error("queue count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/ngga_back.sv
// Parser: header match, field accumulation; one byte per cycle unless stalled.
`default_nettype none

module ngga_back #(
	parameter int TIME_DIGITS     = ngga_pkg::TIME_DIGITS_DEF,
	parameter int MAX_COORD_CHARS = ngga_pkg::MAX_COORD_CHARS_DEF,
	parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_nonempty,
	input  wire ngga_pkg::byte_class_t q_rdata,
	output logic                       q_pop,
	input  wire logic                  res_ready,
	output logic                       res_push,
	output ngga_pkg::raw_result_t      res
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEADER,
		PH_TIME,
		PH_LAT,
		PH_HEMI,
		PH_LON
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [ngga_pkg::HDR_W-1:0]      hdr_pos_q, hdr_pos_d;
	logic                            hdr_ok_q, hdr_ok_d;
	logic [ngga_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [ngga_pkg::TIME_W-1:0]     time_q, time_d;
	logic [ngga_pkg::COORD_W-1:0]    lat_q, lat_d;
	logic [ngga_pkg::COORD_W-1:0]    lon_q, lon_d;
	logic [ngga_pkg::FRAC_W-1:0]     frac_q, frac_d;
	logic [ngga_pkg::FRAC_W-1:0]     lat_frac_q, lat_frac_d;
	logic                            seen_dot_q, seen_dot_d;
	logic                            ended_q, ended_d;

	ngga_pkg::byte_class_t           b;
	logic                            is_result;
	logic [23:0]                     time_mac;
	logic [ngga_pkg::COORD_W-1:0]    coord_acc;
	logic [ngga_pkg::COORD_W+3:0]    coord_wide;
	logic [ngga_pkg::COORD_W-1:0]    coord_mac;
	logic                            c_room, c_wr, c_dot_set, c_frac_inc, c_end_set;

	assign b         = q_rdata;
	assign is_result = (phase_q == PH_LON) && b.comma && !b.dollar;
	assign q_pop     = q_nonempty && (!is_result || res_ready);
	assign res_push  = q_pop && is_result;

	always_comb begin
		res          = '0;
		res.time_raw = time_q;
		res.lat_raw  = lat_q;
		res.lat_frac = lat_frac_q;
		res.lon_raw  = lon_q;
		res.lon_frac = frac_q;
	end

	// Multiply-by-ten units; the coordinate unit is shared by latitude and longitude
	assign time_mac   = (24'(time_q) << 3) + (24'(time_q) << 1) + 24'(b.digit);
	assign coord_acc  = (phase_q == PH_LAT) ? lat_q : lon_q;
	assign coord_wide = ((ngga_pkg::COORD_W+4)'(coord_acc) << 3)
		+ ((ngga_pkg::COORD_W+4)'(coord_acc) << 1) + (ngga_pkg::COORD_W+4)'(b.digit);
	assign coord_mac  = (coord_wide > (ngga_pkg::COORD_W+4)'(ngga_pkg::COORD_CAP))
		? ngga_pkg::COORD_CAP : coord_wide[ngga_pkg::COORD_W-1:0];

	// Coordinate character decode, common to latitude and longitude
	always_comb begin
		c_room     = (cnt_q < ngga_pkg::CNT_W'(MAX_COORD_CHARS));
		c_wr       = 1'b0;
		c_dot_set  = 1'b0;
		c_frac_inc = 1'b0;
		c_end_set  = 1'b0;
		if (c_room && !ended_q) begin
			if (b.is_digit) begin
				if (!seen_dot_q) begin
					c_wr = 1'b1;
				end else if (frac_q < ngga_pkg::FRAC_W'(FRACTION_DIGITS)) begin
					c_wr       = 1'b1;
					c_frac_inc = 1'b1;
				end
			end else if (b.dot && !seen_dot_q) begin
				c_dot_set = 1'b1;
			end else begin
				c_end_set = 1'b1;
			end
		end
	end

	always_comb begin
		phase_d    = phase_q;
		hdr_pos_d  = hdr_pos_q;
		hdr_ok_d   = hdr_ok_q;
		cnt_d      = cnt_q;
		time_d     = time_q;
		lat_d      = lat_q;
		lon_d      = lon_q;
		frac_d     = frac_q;
		lat_frac_d = lat_frac_q;
		seen_dot_d = seen_dot_q;
		ended_d    = ended_q;
		if (q_pop) begin
			if (b.dollar) begin
				// restart on any dollar, dropping the partial sentence
				phase_d    = PH_HEADER;
				hdr_pos_d  = '0;
				hdr_ok_d   = 1'b1;
				time_d     = '0;
				lat_d      = '0;
				lon_d      = '0;
				cnt_d      = '0;
				frac_d     = '0;
				seen_dot_d = 1'b0;
				ended_d    = 1'b0;
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						phase_d = PH_HUNT;
					end
					PH_HEADER: begin
						if (hdr_pos_q >= ngga_pkg::HDR_W'(ngga_pkg::HDR_LEN)) begin
							// sixth header byte is a don't-care separator
							phase_d    = hdr_ok_q ? PH_TIME : PH_HUNT;
							hdr_pos_d  = '0;
							cnt_d      = '0;
							frac_d     = '0;
							seen_dot_d = 1'b0;
							ended_d    = 1'b0;
						end else begin
							if (!b.hdr_hit[hdr_pos_q]) begin
								hdr_ok_d = 1'b0;
							end
							hdr_pos_d = hdr_pos_q + 1'b1;
						end
					end
					PH_TIME: begin
						if (b.comma) begin
							phase_d    = PH_LAT;
							cnt_d      = '0;
							frac_d     = '0;
							seen_dot_d = 1'b0;
							ended_d    = 1'b0;
						end else if (cnt_q < ngga_pkg::CNT_W'(TIME_DIGITS)) begin
							cnt_d = cnt_q + 1'b1;
							if (!ended_q) begin
								if (b.is_digit) begin
									time_d = time_mac[ngga_pkg::TIME_W-1:0];
								end else begin
									ended_d = 1'b1;
								end
							end
						end
					end
					PH_LAT: begin
						if (b.comma) begin
							// hold the fraction count; scaling happens at the result
							lat_frac_d = frac_q;
							phase_d    = PH_HEMI;
							cnt_d      = '0;
							frac_d     = '0;
							seen_dot_d = 1'b0;
							ended_d    = 1'b0;
						end else if (c_room) begin
							cnt_d = cnt_q + 1'b1;
							if (c_wr) begin
								lat_d = coord_mac;
							end
							if (c_frac_inc) begin
								frac_d = frac_q + 1'b1;
							end
							if (c_dot_set) begin
								seen_dot_d = 1'b1;
							end
							if (c_end_set) begin
								ended_d = 1'b1;
							end
						end
					end
					PH_HEMI: begin
						if (b.comma) begin
							phase_d    = PH_LON;
							cnt_d      = '0;
							frac_d     = '0;
							seen_dot_d = 1'b0;
							ended_d    = 1'b0;
						end
					end
					PH_LON: begin
						if (b.comma) begin
							phase_d    = PH_HUNT;
							cnt_d      = '0;
							frac_d     = '0;
							seen_dot_d = 1'b0;
							ended_d    = 1'b0;
						end else if (c_room) begin
							cnt_d = cnt_q + 1'b1;
							if (c_wr) begin
								lon_d = coord_mac;
							end
							if (c_frac_inc) begin
								frac_d = frac_q + 1'b1;
							end
							if (c_dot_set) begin
								seen_dot_d = 1'b1;
							end
							if (c_end_set) begin
								ended_d = 1'b1;
							end
						end
					end
					default: begin
						phase_d = PH_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hdr_pos_q  <= '0;
			hdr_ok_q   <= 1'b1;
			cnt_q      <= '0;
			time_q     <= '0;
			lat_q      <= '0;
			lon_q      <= '0;
			frac_q     <= '0;
			lat_frac_q <= '0;
			seen_dot_q <= 1'b0;
			ended_q    <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			hdr_pos_q  <= hdr_pos_d;
			hdr_ok_q   <= hdr_ok_d;
			cnt_q      <= cnt_d;
			time_q     <= time_d;
			lat_q      <= lat_d;
			lon_q      <= lon_d;
			frac_q     <= frac_d;
			lat_frac_q <= lat_frac_d;
			seen_dot_q <= seen_dot_d;
			ended_q    <= ended_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ngga_finish.sv
// Result stage: fraction scaling, zone shift and the output register.
`default_nettype none

module ngga_finish #(
	parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [ngga_pkg::ZONE_W-1:0]    cfg_wr_data,
	input  wire logic                           res_push,
	input  wire ngga_pkg::raw_result_t          res,
	output logic                                res_ready,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ngga_pkg::TIME_W-1:0]         local_time,
	output logic [ngga_pkg::COORD_W-1:0]        lat_scaled,
	output logic [ngga_pkg::COORD_W-1:0]        lon_scaled
);

	localparam int PROD_W = ngga_pkg::COORD_W + 24;

	logic [ngga_pkg::ZONE_W-1:0]  zone_q;
	logic                         out_valid_q;
	logic [ngga_pkg::TIME_W-1:0]  time_q;
	logic [ngga_pkg::COORD_W-1:0] lat_q;
	logic [ngga_pkg::COORD_W-1:0] lon_q;

	logic [ngga_pkg::FRAC_W-1:0]  lat_m, lon_m;
	logic [PROD_W-1:0]            lat_prod, lon_prod;
	logic [ngga_pkg::COORD_W-1:0] lat_fin, lon_fin;
	logic [ngga_pkg::ZONE_W-1:0]  zone_mod;
	logic [17:0]                  offset;
	logic [20:0]                  t_ext;
	logic [20:0]                  t_shift;

	assign res_ready = !out_valid_q || !out_stall;

	// Append the missing fraction digits as one scaling, saturating at the cap
	assign lat_m    = ngga_pkg::FRAC_W'(FRACTION_DIGITS) - res.lat_frac;
	assign lon_m    = ngga_pkg::FRAC_W'(FRACTION_DIGITS) - res.lon_frac;
	assign lat_prod = PROD_W'(res.lat_raw) * PROD_W'(ngga_pkg::pow10(lat_m));
	assign lon_prod = PROD_W'(res.lon_raw) * PROD_W'(ngga_pkg::pow10(lon_m));
	assign lat_fin  = (res.lat_raw > ngga_pkg::scale_limit(lat_m))
		? ngga_pkg::COORD_CAP : lat_prod[ngga_pkg::COORD_W-1:0];
	assign lon_fin  = (res.lon_raw > ngga_pkg::scale_limit(lon_m))
		? ngga_pkg::COORD_CAP : lon_prod[ngga_pkg::COORD_W-1:0];

	// Zone shift, wrapping below midnight
	assign zone_mod = (zone_q >= ngga_pkg::ZONE_WRAP) ? (zone_q - ngga_pkg::ZONE_WRAP) : zone_q;
	assign offset   = 18'(18'(zone_mod) * ngga_pkg::HOUR_STEP);
	assign t_ext    = 21'(res.time_raw);
	assign t_shift  = (t_ext < 21'(offset)) ? (t_ext + ngga_pkg::DAY_TIME - 21'(offset))
		: (t_ext - 21'(offset));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q      <= ngga_pkg::ZONE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				zone_q <= cfg_wr_data;
			end
			if (res_ready) begin
				out_valid_q <= res_push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_push) begin
			time_q <= t_shift[ngga_pkg::TIME_W-1:0];
			lat_q  <= lat_fin;
			lon_q  <= lon_fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign local_time = time_q;
	assign lat_scaled = lat_q;
	assign lon_scaled = lon_q;

endmodule

`default_nettype wire

>>> rtl/nmea_gga_time_position_parser.sv
// Top level of the GGA sentence parser: front, queue, parser and result stage.
//
// Usage:
//   Input channel: rx_byte with in_valid / in_stall; one character per transfer.
//   Output channel: local_time, lat_scaled, lon_scaled with out_valid / out_stall;
//   one transfer per GGA sentence, issued for the comma that closes longitude.
//   Configuration: cfg_wr_en / cfg_wr_data write zone_offset_hours (reset 8);
//   write only while no sentence is in flight.
// Throughput: one byte per cycle while in_stall is low. The parser makes at
//   most one multiply-by-ten update per byte (time or the coordinate in progress).
// Path: the closing comma passes the classify register, then an entry of the
//   4-entry queue; the parser pops it and the result register loads through the
//   scaling multiply, which raises out_valid.
// Stall: while out_stall holds a result, bytes keep flowing until the next
//   closing comma reaches the parser; then the queue fills and in_stall rises.
// Reset: arst_n clears the queue, the parser returns to hunting for '$', no
//   result is pending and the zone offset returns to 8 hours.
`default_nettype none

module nmea_gga_time_position_parser #(
	parameter int TIME_DIGITS     = ngga_pkg::TIME_DIGITS_DEF,
	parameter int MAX_COORD_CHARS = ngga_pkg::MAX_COORD_CHARS_DEF,
	parameter int FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [ngga_pkg::ZONE_W-1:0]  cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [7:0]                   rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [ngga_pkg::TIME_W-1:0]       local_time,
	output logic [ngga_pkg::COORD_W-1:0]      lat_scaled,
	output logic [ngga_pkg::COORD_W-1:0]      lon_scaled
);

	logic                  q_full;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_nonempty;
	ngga_pkg::byte_class_t q_wdata;
	ngga_pkg::byte_class_t q_rdata;
	logic                  res_ready;
	logic                  res_push;
	ngga_pkg::raw_result_t res;

	ngga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	ngga_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	ngga_back #(
		.TIME_DIGITS     (TIME_DIGITS),
		.MAX_COORD_CHARS (MAX_COORD_CHARS),
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.res_ready  (res_ready),
		.res_push   (res_push),
		.res        (res)
	);

	ngga_finish #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_push    (res_push),
		.res         (res),
		.res_ready   (res_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.local_time  (local_time),
		.lat_scaled  (lat_scaled),
		.lon_scaled  (lon_scaled)
	);

endmodule

`default_nettype wire

>>> bench/nmea_gga_time_position_parser_tb.sv
// Self-checking testbench for the GGA time and position parser.
`timescale 1ns / 100ps

module nmea_gga_time_position_parser_tb;

	localparam int TIME_W  = ngga_pkg::TIME_W;
	localparam int COORD_W = ngga_pkg::COORD_W;
	localparam int ZONE_W  = ngga_pkg::ZONE_W;
	localparam int HDR_LEN = ngga_pkg::HDR_LEN;
	localparam logic [ZONE_W-1:0]  ZONE_RESET  = ngga_pkg::ZONE_RESET;
	localparam logic [COORD_W-1:0] COORD_CAP   = ngga_pkg::COORD_CAP;
	localparam logic [7:0]         CHAR_DOLLAR = ngga_pkg::CHAR_DOLLAR;
	localparam logic [7:0]         CHAR_COMMA  = ngga_pkg::CHAR_COMMA;
	localparam logic [7:0]         CHAR_DOT    = ngga_pkg::CHAR_DOT;
	localparam logic [7:0]         CHAR_ZERO   = ngga_pkg::CHAR_ZERO;
	localparam logic [7:0]         CHAR_NINE   = ngga_pkg::CHAR_NINE;
	localparam logic [7:0]         CHAR_G      = ngga_pkg::CHAR_G;
	localparam logic [7:0]         CHAR_P      = ngga_pkg::CHAR_P;
	localparam logic [7:0]         CHAR_A      = ngga_pkg::CHAR_A;

	localparam int unsigned TIME_CHARS   = ngga_pkg::TIME_DIGITS_DEF;
	localparam int unsigned COORD_CHARS  = ngga_pkg::MAX_COORD_CHARS_DEF;
	localparam int unsigned FRAC_CHARS   = ngga_pkg::FRACTION_DIGITS_DEF;
	localparam int unsigned PHASES       = 7;
	localparam int unsigned PHASE_BYTES  = 190;
	localparam int unsigned PHASE_FIXES  = 5;
	localparam int unsigned LONG_HOLD    = 500;
	localparam int unsigned SETTLE       = 16;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [HDR_LEN-1:0][7:0] GGA_TAG = {CHAR_A, CHAR_G, CHAR_G, CHAR_P, CHAR_G};

	typedef enum logic [2:0] {
		ST_HUNT, ST_HEADER, ST_TIME, ST_LAT, ST_HEMI, ST_LON
	} sentence_state_t;

	typedef struct packed {
		logic [TIME_W-1:0]  hhmmss;
		logic [COORD_W-1:0] lat;
		logic [COORD_W-1:0] lon;
	} gga_fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [ZONE_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [TIME_W-1:0] local_time;
	logic [COORD_W-1:0] lat_scaled;
	logic [COORD_W-1:0] lon_scaled;

	nmea_gga_time_position_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.local_time (local_time),
		.lat_scaled (lat_scaled),
		.lon_scaled (lon_scaled)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sentence parser mirror
	logic [ZONE_W-1:0] zone_hours = ZONE_RESET;
	sentence_state_t parse_state = ST_HUNT;
	int unsigned tag_pos = 0;
	bit tag_ok = 1'b1;
	int unsigned char_cnt = 0;
	int unsigned frac_cnt = 0;
	bit point_seen = 1'b0;
	bit digits_done = 1'b0;
	logic [31:0] clock_acc = '0;
	logic [63:0] lat_acc = '0;
	logic [63:0] lon_acc = '0;

	gga_fix_t expected_fixes [$];
	gga_fix_t oldest_fix;
	logic [7:0] stim_bytes [$];

	bit byte_taken = 1'b0;
	bit steady = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_cycles = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_granted = 0;
	int unsigned cycle_count = 0;
	int unsigned fault_count = 0;
	int unsigned zone_plan [PHASES] = '{0, 23, 31, 24, 1, 17, 5};

	function automatic bit is_digit(logic [7:0] c);
		return c >= CHAR_ZERO && c <= CHAR_NINE;
	endfunction

	function automatic logic [63:0] mac_capped(logic [63:0] acc, logic [7:0] c);
		logic [63:0] v;
		v = acc * 10 + {60'd0, c[3:0]};
		return (v > {30'd0, COORD_CAP}) ? {30'd0, COORD_CAP} : v;
	endfunction

	function automatic void clear_field();
		char_cnt = 0;
		frac_cnt = 0;
		point_seen = 1'b0;
		digits_done = 1'b0;
	endfunction

	function automatic logic [63:0] coord_char(logic [63:0] acc, logic [7:0] c);
		logic [63:0] v;
		v = acc;
		if (char_cnt < COORD_CHARS) begin
			char_cnt++;
			if (!digits_done) begin
				if (is_digit(c)) begin
					if (!point_seen) begin
						v = mac_capped(v, c);
					end else if (frac_cnt < FRAC_CHARS) begin
						v = mac_capped(v, c);
						frac_cnt++;
					end
				end else if (c == CHAR_DOT && !point_seen) begin
					point_seen = 1'b1;
				end else begin
					digits_done = 1'b1;
				end
			end
		end
		return v;
	endfunction

	// Pad the missing fraction digits with zeros
	function automatic logic [63:0] coord_close(logic [63:0] acc);
		logic [63:0] v;
		v = acc;
		for (int unsigned k = frac_cnt; k < FRAC_CHARS; k++)
			v = mac_capped(v, CHAR_ZERO);
		return v;
	endfunction

	function automatic void take_byte(logic [7:0] c);
		gga_fix_t fix;
		int unsigned shift;
		int unsigned shifted;
		if (c == CHAR_DOLLAR) begin
			parse_state = ST_HEADER;
			tag_pos = 0;
			tag_ok = 1'b1;
			clock_acc = '0;
			lat_acc = '0;
			lon_acc = '0;
			clear_field();
		end else begin
			case (parse_state)
				ST_HEADER: begin
					if (tag_pos < HDR_LEN) begin
						if (c != GGA_TAG[tag_pos])
							tag_ok = 1'b0;
						tag_pos++;
					end else begin
						parse_state = tag_ok ? ST_TIME : ST_HUNT;
						tag_pos = 0;
						clear_field();
					end
				end
				ST_TIME: begin
					if (c == CHAR_COMMA) begin
						parse_state = ST_LAT;
						clear_field();
					end else if (char_cnt < TIME_CHARS) begin
						char_cnt++;
						if (!digits_done) begin
							if (is_digit(c))
								clock_acc = clock_acc * 10 + {28'd0, c[3:0]};
							else
								digits_done = 1'b1;
						end
					end
				end
				ST_LAT: begin
					if (c == CHAR_COMMA) begin
						lat_acc = coord_close(lat_acc);
						parse_state = ST_HEMI;
						clear_field();
					end else begin
						lat_acc = coord_char(lat_acc, c);
					end
				end
				ST_HEMI: begin
					if (c == CHAR_COMMA) begin
						parse_state = ST_LON;
						clear_field();
					end
				end
				ST_LON: begin
					if (c == CHAR_COMMA) begin
						lon_acc = coord_close(lon_acc);
						shift = (zone_hours % 24) * 10000;
						if (clock_acc < shift)
							shifted = clock_acc + 240000 - shift;
						else
							shifted = clock_acc - shift;
						fix.hhmmss = shifted[TIME_W-1:0];
						fix.lat = lat_acc[COORD_W-1:0];
						fix.lon = lon_acc[COORD_W-1:0];
						expected_fixes.push_back(fix);
						parse_state = ST_HUNT;
						clear_field();
					end else begin
						lon_acc = coord_char(lon_acc, c);
					end
				end
				default: parse_state = ST_HUNT;
			endcase
		end
	endfunction

	// Mostly no pause, some short, a few long
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 72)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] field_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_COMMA || c == CHAR_DOLLAR);
		return c;
	endfunction

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stim_bytes.push_back(s[i]);
	endtask

	task automatic queue_digit(input int unsigned d);
		stim_bytes.push_back(CHAR_ZERO + d[7:0]);
	endtask

	task automatic queue_random_digits(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			queue_digit($urandom_range(0, 9));
	endtask

	task automatic queue_time_field();
		int unsigned r;
		int unsigned hh;
		int unsigned mm;
		int unsigned ss;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			hh = $urandom_range(0, 23);
			mm = $urandom_range(0, 59);
			ss = $urandom_range(0, 59);
			queue_digit(hh / 10);
			queue_digit(hh % 10);
			queue_digit(mm / 10);
			queue_digit(mm % 10);
			queue_digit(ss / 10);
			queue_digit(ss % 10);
			if ($urandom_range(0, 2) == 0) begin
				stim_bytes.push_back(CHAR_DOT);
				queue_random_digits(2);
			end
		end else if (r < 88) begin
			queue_random_digits($urandom_range(0, 9));
		end else begin
			repeat ($urandom_range(1, 4))
				stim_bytes.push_back(field_byte());
		end
	endtask

	task automatic queue_coord_field();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			queue_random_digits($urandom_range(3, 5));
		else if (r < 90)
			queue_random_digits($urandom_range(0, 2));
		else
			queue_random_digits($urandom_range(10, 14));
		if ($urandom_range(0, 99) < 85) begin
			stim_bytes.push_back(CHAR_DOT);
			queue_random_digits($urandom_range(0, 8));
		end
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 3))
				stim_bytes.push_back(field_byte());
		end
	endtask

	// One GGA sentence with random content, now and then corrupted or cut short
	task automatic queue_sentence(output bit whole, output int unsigned count);
		int unsigned start;
		int unsigned bad_pos;
		int unsigned cut;
		start = stim_bytes.size();
		stim_bytes.push_back(CHAR_DOLLAR);
		bad_pos = ($urandom_range(0, 99) < 8) ? $urandom_range(0, HDR_LEN - 1) : HDR_LEN;
		for (int unsigned i = 0; i < HDR_LEN; i++)
			stim_bytes.push_back((i == bad_pos) ? field_byte() : GGA_TAG[i]);
		stim_bytes.push_back(($urandom_range(0, 99) < 92) ? CHAR_COMMA : field_byte());
		queue_time_field();
		stim_bytes.push_back(CHAR_COMMA);
		queue_coord_field();
		stim_bytes.push_back(CHAR_COMMA);
		repeat ($urandom_range(0, 2))
			stim_bytes.push_back(field_byte());
		stim_bytes.push_back(CHAR_COMMA);
		queue_coord_field();
		stim_bytes.push_back(CHAR_COMMA);
		whole = (bad_pos == HDR_LEN);
		if ($urandom_range(0, 99) < 8) begin
			cut = start + $urandom_range(1, stim_bytes.size() - start - 1);
			while (stim_bytes.size() > cut)
				void'(stim_bytes.pop_back());
			whole = 1'b0;
		end
		count = stim_bytes.size() - start;
	endtask

	task automatic queue_phase();
		int unsigned sent;
		int unsigned good;
		int unsigned n;
		bit whole;
		sent = 0;
		good = 0;
		while (sent < PHASE_BYTES || good < PHASE_FIXES) begin
			queue_sentence(whole, n);
			sent += n;
			good += whole;
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 6))
					stim_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Hold the sender until every expected fix has come out
	task automatic wait_drained();
		while (stim_bytes.size() != 0 || in_valid || expected_fixes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_zone(input int unsigned hours);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hours[ZONE_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Byte driver: advance on a transfer, otherwise hold the payload
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (stim_bytes.size() != 0) begin
				rx_byte <= stim_bytes.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles != 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (holds_granted != holds_asked) begin
				holds_granted++;
				hold_cycles = LONG_HOLD;
				out_stall <= 1'b1;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_idle();
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: track config, predict on byte transfers, check result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			byte_taken <= in_valid && !in_stall;
			if (cfg_wr_en)
				zone_hours = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_fixes.size() == 0) begin
					$error("result with none pending: local_time %0d lat_scaled %0d lon_scaled %0d",
						local_time, lat_scaled, lon_scaled);
					fault_count++;
				end else begin
					oldest_fix = expected_fixes.pop_front();
					if (local_time !== oldest_fix.hhmmss) begin
						$error("local_time: expected %0d, got %0d", oldest_fix.hhmmss, local_time);
						fault_count++;
					end
					if (lat_scaled !== oldest_fix.lat) begin
						$error("lat_scaled: expected %0d, got %0d", oldest_fix.lat, lat_scaled);
						fault_count++;
					end
					if (lon_scaled !== oldest_fix.lon) begin
						$error("lon_scaled: expected %0d, got %0d", oldest_fix.lon, lon_scaled);
						fault_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				take_byte(rx_byte);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nmea_gga_time_position_parser verification failed");
			$finish;
		end
	end

	initial begin
		zone_plan[5] = $urandom_range(0, 31);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty fields; header mismatch broken by a restart, long time field,
		// extra fraction digits and a saturated longitude; stray bytes
		queue_text("$GPGGA,,,,,");
		queue_text("$GPGA$GPGGA,2359591,0.1234567,,99999999999.5,");
		stim_bytes.push_back(8'h00);
		stim_bytes.push_back(8'hFF);
		queue_phase();

		for (int unsigned p = 0; p < PHASES; p++) begin
			wait_drained();
			write_zone(zone_plan[p]);
			steady = (p == 2);
			if (p == 4)
				holds_asked++;
			queue_phase();
		end
		wait_drained();
		steady = 1'b0;

		if (fault_count == 0 && expected_fixes.size() == 0)
			$display("nmea_gga_time_position_parser verification clean");
		else
			$display("nmea_gga_time_position_parser verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/ngga_pkg.sv
rtl/ngga_front.sv
rtl/ngga_queue.sv
rtl/ngga_back.sv
rtl/ngga_finish.sv
rtl/nmea_gga_time_position_parser.sv
bench/nmea_gga_time_position_parser_tb.sv
